// ===== design/hef_pkg.sv =====
// Shared types and constants for the histogram extrema finder.
`default_nettype none

package hef_pkg;

  localparam int POS_BITS    = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Direction of the step into the current run of equal counts
  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_UP   = 2'd1,
    STEP_DOWN = 2'd2
  } step_t;

  typedef struct packed {
    logic [POS_BITS-1:0] position;
    logic                found;
    logic                last_of_list;
  } result_t;

  // Everything one bin produces: one or two results
  typedef struct packed {
    logic    two;
    result_t res0;
    result_t res1;
  } bundle_t;

endpackage

`default_nettype wire

// ===== design/hef_front.sv =====
// Front end: tracks runs of equal counts and classifies each bin into results.
`default_nettype none

module hef_front #(
  parameter int MAX_BINS   = 256,
  parameter int COUNT_BITS = 24
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     kind_max,
  input  wire                     accept,
  input  wire [COUNT_BITS-1:0]    bin_count,
  input  wire                     last_bin,
  output logic                    push,
  output hef_pkg::bundle_t        bundle
);
  import hef_pkg::*;

  localparam int IDX_W = $clog2(MAX_BINS);

  logic [COUNT_BITS-1:0] prev_r, prev_nxt;
  step_t                 sign_r, sign_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [IDX_W-1:0]      start_r, start_nxt;
  logic                  open_r, open_nxt;

  logic             last;
  logic             differ;
  logic             rising;
  logic [IDX_W:0]   sum_a;
  logic [IDX_W:0]   sum_b;
  logic [IDX_W-1:0] centre_a;
  logic [IDX_W-1:0] pos_b;
  logic             emit_a;
  logic             emit_b;
  step_t            new_sign;
  logic [IDX_W-1:0] new_start;
  result_t          res_a;
  result_t          res_b;
  result_t          res_empty;

  always_comb begin
    last     = last_bin || (idx_r == IDX_W'(MAX_BINS - 1));
    differ   = bin_count != prev_r;
    rising   = bin_count > prev_r;
    sum_a    = {1'b0, start_r} + {1'b0, idx_r - IDX_W'(1)};
    centre_a = IDX_W'(sum_a >> 1);

    new_sign  = differ ? (rising ? STEP_UP : STEP_DOWN) : sign_r;
    new_start = differ ? idx_r : start_r;
    sum_b     = {1'b0, new_start} + {1'b0, idx_r};

    if (!open_r) begin
      // first bin of a histogram is index 0
      emit_a = 1'b0;
      emit_b = !kind_max || last;
      pos_b  = '0;
    end else begin
      if (kind_max) begin
        emit_a = differ && (sign_r != STEP_DOWN) && !rising;
        emit_b = last && (new_sign != STEP_DOWN);
        pos_b  = IDX_W'(sum_b >> 1);
      end else begin
        emit_a = differ && (sign_r == STEP_DOWN) && rising;
        emit_b = last;
        pos_b  = idx_r;
      end
    end

    res_a.position     = POS_BITS'(centre_a);
    res_a.found        = 1'b1;
    res_a.last_of_list = last && !emit_b;
    res_b.position     = POS_BITS'(pos_b);
    res_b.found        = 1'b1;
    res_b.last_of_list = last;
    res_empty.position     = '0;
    res_empty.found        = 1'b0;
    res_empty.last_of_list = 1'b1;

    push        = accept && (emit_a || emit_b || last);
    bundle.two  = emit_a && emit_b;
    bundle.res1 = res_b;
    if (emit_a) begin
      bundle.res0 = res_a;
    end else if (emit_b) begin
      bundle.res0 = res_b;
    end else begin
      bundle.res0 = res_empty;
    end
  end

  always_comb begin
    prev_nxt  = prev_r;
    sign_nxt  = sign_r;
    idx_nxt   = idx_r;
    start_nxt = start_r;
    open_nxt  = open_r;
    if (accept) begin
      if (last) begin
        prev_nxt  = '0;
        sign_nxt  = STEP_NONE;
        idx_nxt   = '0;
        start_nxt = '0;
        open_nxt  = 1'b0;
      end else begin
        prev_nxt  = bin_count;
        idx_nxt   = idx_r + IDX_W'(1);
        open_nxt  = 1'b1;
        sign_nxt  = open_r ? new_sign : STEP_NONE;
        start_nxt = open_r ? new_start : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      sign_r  <= STEP_NONE;
      idx_r   <= '0;
      start_r <= '0;
      open_r  <= 1'b0;
    end else begin
      prev_r  <= prev_nxt;
      sign_r  <= sign_nxt;
      idx_r   <= idx_nxt;
      start_r <= start_nxt;
      open_r  <= open_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/hef_queue.sv =====
// Short queue of result bundles between front and back end.
`default_nettype none

module hef_queue (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               push,
  input  hef_pkg::bundle_t  push_data,
  input  wire               pop,
  output hef_pkg::bundle_t  head,
  output logic              not_empty,
  output logic              full
);
  import hef_pkg::*;

  bundle_t              mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_AW:0]    cnt_r, cnt_nxt;

  always_comb begin
    not_empty  = cnt_r != '0;
    full       = cnt_r == (QUEUE_AW+1)'(QUEUE_DEPTH);
    head       = mem[rd_ptr_r];
    wr_ptr_nxt = push ? wr_ptr_r + QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QUEUE_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/hef_back.sv =====
// Back end: splits bundles into single results into the output register.
`default_nettype none

module hef_back (
  input  wire                clk,
  input  wire                rst_n,
  input  hef_pkg::bundle_t   head,
  input  wire                head_valid,
  output logic               pop,
  output logic               out_valid,
  input  wire                out_ready,
  output hef_pkg::result_t   out_res
);
  import hef_pkg::*;

  logic    valid_r, valid_nxt;
  logic    sel_r, sel_nxt;
  result_t res_r, res_nxt;
  logic    load;

  always_comb begin
    load      = head_valid && (!valid_r || out_ready);
    pop       = load && (sel_r || !head.two);
    valid_nxt = valid_r;
    sel_nxt   = sel_r;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = sel_r ? head.res1 : head.res0;
      sel_nxt   = !sel_r && head.two;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
    out_valid = valid_r;
    out_res   = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sel_r   <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

`default_nettype wire

// ===== design/histogram_extrema_finder_top.sv =====
// Histogram extrema finder: top level.
//
// Bin counts enter on the in_ stream, bin 0 first, in_tlast on the final bin
// (a bin at index MAX_BINS-1 closes the histogram regardless). Results leave
// on the out_ stream in ascending bin order; out_tlast marks the final one of
// a histogram, out_tuser low marks the empty closing record.
// cfg_wr_data selects minima with endpoints (0) or maxima (1); write it only
// while no histogram is in flight.
// One bin is accepted per cycle while the queue has room. A bin yielding
// two results sends them one result per cycle while out_tready is high;
// a four-entry queue between the classifier and the output stage absorbs
// such bursts, and in_tready drops only when that queue is full.
// The first result of a bin is written into the queue when the bin is
// accepted and then into the output register, which drives the out_ port.
// A stalled receiver holds the output register; the queue keeps filling
// until full, then in_tready goes low.
// Reset (synchronous, rst_n low) empties queue and output and returns the
// run tracker to the start of a histogram; the mode register resets to minima.
`default_nettype none

module histogram_extrema_finder_top #(
  parameter int MAX_BINS   = 256,
  parameter int COUNT_BITS = 24
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,   // [23:0] bin_count
  input  wire         in_tlast,   // last_bin
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [7:0]  out_tdata,  // [7:0] position
  output logic        out_tuser,  // found
  output logic        out_tlast,  // last_of_list
  input  wire         cfg_wr_en,
  input  wire         cfg_wr_data // extremum_kind
);
  import hef_pkg::*;

  logic                  kind_r;
  logic                  accept;
  logic                  push;
  logic                  pop;
  logic                  not_empty;
  logic                  full;
  logic [COUNT_BITS-1:0] count;
  bundle_t               push_data;
  bundle_t               head;
  result_t               res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= 1'b0;
    end else if (cfg_wr_en) begin
      kind_r <= cfg_wr_data;
    end
  end

  assign in_tready = !full;
  assign accept    = in_tvalid && in_tready;
  assign count     = COUNT_BITS'(in_tdata);

  hef_front #(
    .MAX_BINS   (MAX_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .kind_max  (kind_r),
    .accept    (accept),
    .bin_count (count),
    .last_bin  (in_tlast),
    .push      (push),
    .bundle    (push_data)
  );

  hef_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  hef_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (not_empty),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_res    (res)
  );

  assign out_tdata = res.position;
  assign out_tuser = res.found;
  assign out_tlast = res.last_of_list;

endmodule

`default_nettype wire

// ===== design/hef_checker.sv =====
// Port-level checks for the histogram extrema finder, bound to the top level.
`default_nettype none

module hef_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_tvalid,
  input wire       out_tready,
  input wire [7:0] out_tdata,
  input wire       out_tuser,
  input wire       out_tlast
);

  // output register holds a stalled transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled output transaction changed");

  // empty record always closes the list
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tlast)
    else $error("empty record without tlast");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 8'd0)
    else $error("empty record with nonzero position");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

endmodule

bind histogram_extrema_finder_top hef_checker u_hef_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
